/* rtl/core/hvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_pkg: shared types and constants
// Operation codes, register offsets and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [4:0] REG_NMITIMEN = 5'h00;
  localparam logic [4:0] REG_WRIO     = 5'h01;
  localparam logic [4:0] REG_WRMPYA   = 5'h02;
  localparam logic [4:0] REG_WRMPYB   = 5'h03;
  localparam logic [4:0] REG_WRDIVL   = 5'h04;
  localparam logic [4:0] REG_WRDIVH   = 5'h05;
  localparam logic [4:0] REG_WRDIVB   = 5'h06;
  localparam logic [4:0] REG_HTIMEL   = 5'h07;
  localparam logic [4:0] REG_HTIMEH   = 5'h08;
  localparam logic [4:0] REG_VTIMEL   = 5'h09;
  localparam logic [4:0] REG_VTIMEH   = 5'h0a;
  localparam logic [4:0] REG_RDNMI    = 5'h10;
  localparam logic [4:0] REG_TIMEUP   = 5'h11;
  localparam logic [4:0] REG_HVBJOY   = 5'h12;
  localparam logic [4:0] REG_RDIO     = 5'h13;
  localparam logic [4:0] REG_RDDIVL   = 5'h14;
  localparam logic [4:0] REG_RDDIVH   = 5'h15;
  localparam logic [4:0] REG_RDMPYL   = 5'h16;
  localparam logic [4:0] REG_RDMPYH   = 5'h17;

  typedef struct packed {
    logic       start;      // apply the captured item
    logic       div_start;  // begin a division
    logic       div_step;   // one restoring step
    logic       div_done;   // store quotient and remainder
  } hvt_cmd_t;

  typedef struct packed {
    logic       is_div;     // captured item starts a division
  } hvt_status_t;

endpackage

/* rtl/core/hvt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_ctrl: sequencing controller
// Accepts an item, sequences the datapath, and holds the result until it is
// taken. A nonzero divide write runs sixteen shift-subtract steps.
// ----------------------------------------------------------------------------
module hvt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  hvt_pkg::hvt_status_t status,
  output hvt_pkg::hvt_cmd_t    cmd
);
  import hvt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_OUT} state_t;

  state_t     state;
  logic [3:0] step_cnt;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.start     = (state == S_EXEC);
    cmd.div_start = (state == S_EXEC) && status.is_div;
    cmd.div_step  = (state == S_DIV);
    cmd.div_done  = (state == S_DIV) && (step_cnt == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          step_cnt <= '0;
          state    <= status.is_div ? S_DIV : S_OUT;
        end
        S_DIV: begin
          step_cnt <= step_cnt + 4'd1;
          if (step_cnt == 4'd15) state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_only_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.div_step) |-> $past(cmd.div_start))
    else $error("division started without a divide write");
  a_done_leads_out: assert property (@(posedge clk) disable iff (rst)
    cmd.div_done |=> out_valid)
    else $error("division finish did not present a result");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result waits");
`endif

endmodule

/* rtl/core/hvt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvt_datapath: counters, flags and arithmetic registers
// Holds the video counters, IRQ/NMI logic, register file, the 8x8 multiplier
// and a bit-serial 16/8 divider, and forms the result item.
// ----------------------------------------------------------------------------
module hvt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                pal_timing,
  input  logic                capture,
  input  logic [1:0]          operation,
  input  logic [4:0]          reg_offset,
  input  logic [7:0]          write_data,
  input  logic [7:0]          open_bus,
  input  logic                interlace,
  input  logic                even_frame,
  input  logic                overscan,
  input  hvt_pkg::hvt_cmd_t    cmd,
  output hvt_pkg::hvt_status_t status,
  output logic [7:0]          read_data,
  output logic                irq_line,
  output logic                nmi_pulse,
  output logic                hdma_init_request,
  output logic                hdma_run_request,
  output logic                vblank_begin,
  output logic                frame_begin,
  output logic                latch_counters,
  output logic [10:0]         h_position,
  output logic [8:0]          v_position
);
  import hvt_pkg::*;

  // Captured item.
  logic [1:0]  op_q;
  logic [4:0]  off_q;
  logic [7:0]  wd_q, ob_q;
  logic        il_q, ev_q, os_q;

  logic [10:0] dot_count, next_event_dot, dot_compare;
  logic [8:0]  line_count, line_compare;
  logic [2:0]  irq_delay;
  logic        compare_hit_prev, irq_flag, nmi_flag, vblank_flag, latch_bit;
  logic [2:0]  enable_bits;
  logic [7:0]  multiplicand;
  logic [15:0] product_remainder, dividend, quotient;

  // Divider working registers.
  logic [15:0] div_q;
  logic [7:0]  div_r;
  logic [7:0]  divisor;
  logic [8:0]  div_sh;
  logic [7:0]  div_rn;
  logic        div_nb;

  assign status.is_div = (op_q == OP_WRITE) && (off_q == REG_WRDIVB)
                         && (wd_q != 8'd0);

  always_ff @(posedge clk) begin
    if (capture) begin
      op_q  <= operation;
      off_q <= reg_offset;
      wd_q  <= write_data;
      ob_q  <= open_bus;
      il_q  <= interlace;
      ev_q  <= even_frame;
      os_q  <= overscan;
    end
  end

  // Tick next-state logic.
  logic        hen, ven, cond, ev_hit, short_frame, start_vbl;
  logic [2:0]  delay_t;
  logic        irqf_t;
  logic [10:0] dot_adv;
  logic [8:0]  line_inc, line_wrap;

  always_comb begin
    hen     = enable_bits[0];
    ven     = enable_bits[1];
    delay_t = irq_delay;
    irqf_t  = irq_flag;
    if (irq_delay != 3'd0) begin
      delay_t = (irq_delay >= 3'd2) ? irq_delay - 3'd2 : 3'd0;
      if (delay_t == 3'd0) irqf_t = 1'b1;
    end
    cond = (hen || ven) && (line_count == line_compare || !ven)
           && (dot_count == dot_compare || !hen);
    if (!compare_hit_prev && cond) delay_t = 3'd4;
    dot_adv     = dot_count + 11'd2;
    ev_hit      = (dot_adv == next_event_dot);
    short_frame = !il_q || !ev_q;
    line_inc    = line_count + 9'd1;
    if (!pal_timing)
      line_wrap = ((line_inc == 9'd262 && short_frame) || line_inc == 9'd263)
                  ? 9'd0 : line_inc;
    else
      line_wrap = ((line_inc == 9'd312 && short_frame) || line_inc == 9'd313)
                  ? 9'd0 : line_inc;
    start_vbl = 1'b0;
    if (line_wrap == 9'd225) start_vbl = !os_q;
    else if (line_wrap == 9'd240) start_vbl = !vblank_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count <= '0; line_count <= '0; next_event_dot <= 11'd16;
      dot_compare <= 11'd2044; line_compare <= 9'd511;
      irq_delay <= '0; compare_hit_prev <= 1'b0; irq_flag <= 1'b0;
      nmi_flag <= 1'b0; vblank_flag <= 1'b0; enable_bits <= '0;
      latch_bit <= 1'b1; multiplicand <= 8'd255;
      product_remainder <= 16'hfe01; dividend <= 16'hffff;
      quotient <= 16'h0101;
      read_data <= '0; nmi_pulse <= 1'b0; hdma_init_request <= 1'b0;
      hdma_run_request <= 1'b0; vblank_begin <= 1'b0; frame_begin <= 1'b0;
      latch_counters <= 1'b0;
    end else if (cmd.start) begin
      read_data <= '0; nmi_pulse <= 1'b0; hdma_init_request <= 1'b0;
      hdma_run_request <= 1'b0; vblank_begin <= 1'b0; frame_begin <= 1'b0;
      latch_counters <= 1'b0;
      case (op_q)
        OP_TICK: begin
          if (!dot_count[1]) begin
            irq_delay        <= delay_t;
            irq_flag         <= irqf_t;
            compare_hit_prev <= cond;
          end
          dot_count <= dot_adv;
          if (ev_hit) begin
            case (dot_adv)
              11'd16: begin
                next_event_dot <= 11'd22;
                if (line_count == 9'd0) hdma_init_request <= 1'b1;
              end
              11'd22:  next_event_dot <= 11'd512;
              11'd512: next_event_dot <= 11'd538;
              11'd538: next_event_dot <= 11'd1104;
              11'd1104: begin
                if (!vblank_flag) hdma_run_request <= 1'b1;
                if (!pal_timing)
                  next_event_dot <= (line_count == 9'd240 && !ev_q && !il_q)
                                    ? 11'd1360 : 11'd1364;
                else
                  next_event_dot <= (line_count != 9'd311 || ev_q || !il_q)
                                    ? 11'd1364 : 11'd1368;
              end
              11'd1360, 11'd1364, 11'd1368: begin
                next_event_dot <= 11'd16;
                dot_count      <= '0;
                line_count     <= line_wrap;
                if (line_wrap == 9'd0) begin
                  vblank_flag <= 1'b0;
                  nmi_flag    <= 1'b0;
                  frame_begin <= 1'b1;
                end else if (start_vbl) begin
                  vblank_flag  <= 1'b1;
                  nmi_flag     <= 1'b1;
                  vblank_begin <= 1'b1;
                  if (enable_bits[2]) nmi_pulse <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        OP_READ: begin
          case (off_q)
            REG_RDNMI: begin
              read_data <= {nmi_flag, 7'h02 | (ob_q[6:0] & 7'h70)};
              nmi_flag  <= 1'b0;
            end
            REG_TIMEUP: begin
              read_data <= {irq_flag, ob_q[6:0]};
              irq_flag  <= 1'b0;
            end
            REG_HVBJOY: read_data <= {vblank_flag,
                (dot_count < 11'd4 || dot_count >= 11'd1096), ob_q[5:1], 1'b0};
            REG_RDIO:   read_data <= {latch_bit, 7'd0};
            REG_RDDIVL: read_data <= quotient[7:0];
            REG_RDDIVH: read_data <= quotient[15:8];
            REG_RDMPYL: read_data <= product_remainder[7:0];
            REG_RDMPYH: read_data <= product_remainder[15:8];
            default:    read_data <= off_q[4:3] == 2'b11 ? 8'd0 : ob_q;
          endcase
        end
        OP_WRITE: begin
          case (off_q)
            REG_NMITIMEN: begin
              if (wd_q[5:4] == 2'b00) irq_flag <= 1'b0;
              if (!enable_bits[2] && wd_q[7] && nmi_flag) nmi_pulse <= 1'b1;
              enable_bits <= {wd_q[7], wd_q[5], wd_q[4]};
            end
            REG_WRIO: begin
              if (!wd_q[7] && latch_bit) latch_counters <= 1'b1;
              latch_bit <= wd_q[7];
            end
            REG_WRMPYA: multiplicand <= wd_q;
            REG_WRMPYB: product_remainder <= multiplicand * wd_q;
            REG_WRDIVL: dividend[7:0]  <= wd_q;
            REG_WRDIVH: dividend[15:8] <= wd_q;
            REG_WRDIVB: begin
              if (wd_q == 8'd0) begin
                quotient          <= 16'hffff;
                product_remainder <= dividend;
              end
            end
            REG_HTIMEL: dot_compare[9:2] <= wd_q;
            REG_HTIMEH: dot_compare[10]  <= wd_q[0];
            REG_VTIMEL: line_compare[7:0] <= wd_q;
            REG_VTIMEH: line_compare[8]   <= wd_q[0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end else if (cmd.div_done) begin
      quotient          <= {div_q[14:0], div_nb};
      product_remainder <= {8'd0, div_rn};
    end
  end

  // Restoring divider, one quotient bit per step.
  always_comb begin
    div_sh = {div_r, div_q[15]};
    div_nb = (div_sh >= {1'b0, divisor});
    div_rn = div_nb ? 8'(div_sh - {1'b0, divisor}) : div_sh[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= dividend;
      div_r   <= '0;
      divisor <= wd_q;
    end else if (cmd.div_step) begin
      div_q <= {div_q[14:0], div_nb};
      div_r <= div_rn;
    end
  end

  assign irq_line   = irq_flag;
  assign h_position = dot_count;
  assign v_position = line_count;

`ifndef SYNTHESIS
  a_dot_even: assert property (@(posedge clk) disable iff (rst)
    !dot_count[0])
    else $error("dot counter became odd");
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    frame_begin |-> line_count == 9'd0 && !vblank_flag)
    else $error("frame start without line zero");
  a_vbl_sets: assert property (@(posedge clk) disable iff (rst)
    vblank_begin |-> vblank_flag && nmi_flag)
    else $error("vblank start without flags");
`endif

endmodule

/* rtl/core/hv_timer_irq_and_muldiv_registers_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_timer_irq_and_muldiv_registers_core: video timer and arithmetic registers
// Ticks the dot/line counters, raises timer IRQ and NMI, serves the register
// page including the multiplier and divider.
// ----------------------------------------------------------------------------
// Sequence: a transfer is captured, executed in state S_EXEC and presented
// in S_OUT; a nonzero divide write runs the 16-step serial divider between.
// Items run one at a time: the next is accepted once the result is taken.
// Reset: synchronous; counters, flags and arithmetic registers take their
// power-on values.
module hv_timer_irq_and_muldiv_registers_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [4:0]  reg_offset,
  input  logic [7:0]  write_data,
  input  logic [7:0]  open_bus,
  input  logic        interlace,
  input  logic        even_frame,
  input  logic        overscan,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        irq_line,
  output logic        nmi_pulse,
  output logic        hdma_init_request,
  output logic        hdma_run_request,
  output logic        vblank_begin,
  output logic        frame_begin,
  output logic        latch_counters,
  output logic [10:0] h_position,
  output logic [8:0]  v_position
);
  import hvt_pkg::*;

  logic        pal_timing;
  hvt_cmd_t    cmd;
  hvt_status_t status;

  always_ff @(posedge clk) begin
    if (rst) pal_timing <= 1'b0;
    else if (cfg_we) pal_timing <= cfg_wdata;
  end

  hvt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  hvt_datapath u_dp (
    .clk(clk), .rst(rst), .pal_timing(pal_timing),
    .capture(in_valid && in_ready),
    .operation(operation), .reg_offset(reg_offset), .write_data(write_data),
    .open_bus(open_bus), .interlace(interlace), .even_frame(even_frame),
    .overscan(overscan), .cmd(cmd), .status(status),
    .read_data(read_data), .irq_line(irq_line), .nmi_pulse(nmi_pulse),
    .hdma_init_request(hdma_init_request), .hdma_run_request(hdma_run_request),
    .vblank_begin(vblank_begin), .frame_begin(frame_begin),
    .latch_counters(latch_counters), .h_position(h_position),
    .v_position(v_position)
  );

endmodule

/* tb/sv/hv_timer_irq_and_muldiv_registers_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_timer_irq_and_muldiv_registers_core_test: self-checking testbench
// Drives ticks, register reads and writes through the valid/ready input and
// compares every result transfer with a cycle-free model of the dot/line
// timer, the IRQ/NMI flags and the multiplier/divider registers.
// ----------------------------------------------------------------------------
module hv_timer_irq_and_muldiv_registers_core_test;
  import hvt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2500000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct {
    logic [1:0] op;
    logic [4:0] off;
    logic [7:0] wd;
    logic [7:0] ob;
    logic       il;
    logic       ev;
    logic       os;
  } bus_item_t;

  typedef struct {
    logic [7:0]  rd;
    logic        irq;
    logic        nmi;
    logic        hinit;
    logic        hrun;
    logic        vbl;
    logic        frame;
    logic        latch;
    logic [10:0] hpos;
    logic [8:0]  vpos;
  } timer_result_t;

  class hvt_timer_board;
    logic        pal;
    logic [10:0] dot, next_dot, dot_cmp;
    logic [8:0]  line, line_cmp;
    logic [2:0]  irq_wait, en;
    logic        hit_prev, irq_f, nmi_f, vbl_f, latch_f;
    logic [7:0]  mcand;
    logic [15:0] prod_rem, dvd, quot;
    int          errors;
    timer_result_t pending_results[$];
    timer_result_t r;

    function new();
      pal = 0; dot = 0; line = 0; next_dot = 16; dot_cmp = 2044; line_cmp = 511;
      irq_wait = 0; hit_prev = 0; irq_f = 0; nmi_f = 0; vbl_f = 0; en = 0;
      latch_f = 1; mcand = 255; prod_rem = 65025; dvd = 65535; quot = 257;
      errors = 0;
    endfunction

    function void advance_dot(logic il, logic ev, logic os);
      logic cond, start_vbl, short_frame;
      if (!dot[1]) begin
        if (irq_wait > 0) begin
          irq_wait = (irq_wait >= 2) ? irq_wait - 3'd2 : 3'd0;
          if (irq_wait == 0) irq_f = 1;
        end
        cond = (en[0] || en[1]) && (line == line_cmp || !en[1]) &&
               (dot == dot_cmp || !en[0]);
        if (!hit_prev && cond) irq_wait = 4;
        hit_prev = cond;
      end
      dot = dot + 11'd2;
      if (dot != next_dot) return;
      case (dot)
        11'd16: begin
          next_dot = 22;
          if (line == 0) r.hinit = 1;
        end
        11'd22: next_dot = 512;
        11'd512: next_dot = 538;
        11'd538: next_dot = 1104;
        11'd1104: begin
          if (!vbl_f) r.hrun = 1;
          if (!pal) next_dot = (line == 240 && !ev && !il) ? 11'd1360 : 11'd1364;
          else next_dot = (line != 311 || ev || !il) ? 11'd1364 : 11'd1368;
        end
        11'd1360, 11'd1364, 11'd1368: begin
          start_vbl = 0;
          short_frame = !il || !ev;
          next_dot = 16;
          dot = 0;
          line = line + 9'd1;
          if (!pal) begin
            if ((line == 262 && short_frame) || line == 263) line = 0;
          end else begin
            if ((line == 312 && short_frame) || line == 313) line = 0;
          end
          if (line == 0) begin
            vbl_f = 0;
            nmi_f = 0;
            r.frame = 1;
          end else if (line == 225) begin
            start_vbl = !os;
          end else if (line == 240) begin
            if (!vbl_f) start_vbl = 1;
          end
          if (start_vbl) begin
            vbl_f = 1;
            nmi_f = 1;
            r.vbl = 1;
            if (en[2]) r.nmi = 1;
          end
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] read_reg(logic [4:0] off, logic [7:0] ob);
      logic [7:0] v;
      case (off)
        REG_RDNMI: begin
          v = {nmi_f, 7'h02} | (ob & 8'h70);
          nmi_f = 0;
        end
        REG_TIMEUP: begin
          v = {irq_f, ob[6:0]};
          irq_f = 0;
        end
        REG_HVBJOY: v = {vbl_f, (dot < 4 || dot >= 1096), 6'h00} | (ob & 8'h3e);
        REG_RDIO:   v = {latch_f, 7'h00};
        REG_RDDIVL: v = quot[7:0];
        REG_RDDIVH: v = quot[15:8];
        REG_RDMPYL: v = prod_rem[7:0];
        REG_RDMPYH: v = prod_rem[15:8];
        default:    v = (off >= 5'h18) ? 8'h00 : ob;
      endcase
      return v;
    endfunction

    function void write_reg(logic [4:0] off, logic [7:0] val);
      case (off)
        REG_NMITIMEN: begin
          if (val[5:4] == 0) irq_f = 0;
          if (!en[2] && val[7] && nmi_f) r.nmi = 1;
          en = {val[7], val[5], val[4]};
        end
        REG_WRIO: begin
          if (!val[7] && latch_f) r.latch = 1;
          latch_f = val[7];
        end
        REG_WRMPYA: mcand = val;
        REG_WRMPYB: prod_rem = mcand * val;
        REG_WRDIVL: dvd[7:0] = val;
        REG_WRDIVH: dvd[15:8] = val;
        REG_WRDIVB: begin
          if (val == 0) begin
            quot = 16'hffff;
            prod_rem = dvd;
          end else begin
            quot = dvd / val;
            prod_rem = dvd % val;
          end
        end
        REG_HTIMEL: dot_cmp = {dot_cmp[10], val, 2'b00};
        REG_HTIMEH: dot_cmp = {val[0], dot_cmp[9:2], 2'b00};
        REG_VTIMEL: line_cmp = {line_cmp[8], val};
        REG_VTIMEH: line_cmp = {val[0], line_cmp[7:0]};
        default: ;
      endcase
    endfunction

    function void note_transfer(bus_item_t it);
      r = '{default: '0};
      case (it.op)
        OP_TICK:  advance_dot(it.il, it.ev, it.os);
        OP_READ:  r.rd = read_reg(it.off, it.ob);
        OP_WRITE: write_reg(it.off, it.wd);
        default: ;
      endcase
      r.irq = irq_f;
      r.hpos = dot;
      r.vpos = line;
      pending_results.push_back(r);
    endfunction

    function void cmp_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(timer_result_t a);
      timer_result_t e;
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp_field("read_data", int'(e.rd), int'(a.rd));
      cmp_field("irq_line", int'(e.irq), int'(a.irq));
      cmp_field("nmi_pulse", int'(e.nmi), int'(a.nmi));
      cmp_field("hdma_init_request", int'(e.hinit), int'(a.hinit));
      cmp_field("hdma_run_request", int'(e.hrun), int'(a.hrun));
      cmp_field("vblank_begin", int'(e.vbl), int'(a.vbl));
      cmp_field("frame_begin", int'(e.frame), int'(a.frame));
      cmp_field("latch_counters", int'(e.latch), int'(a.latch));
      cmp_field("h_position", int'(e.hpos), int'(a.hpos));
      cmp_field("v_position", int'(e.vpos), int'(a.vpos));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst;
  logic        cfg_we, cfg_wdata;
  logic        in_valid, in_ready;
  logic [1:0]  operation;
  logic [4:0]  reg_offset;
  logic [7:0]  write_data, open_bus;
  logic        interlace, even_frame, overscan;
  logic        out_valid, out_ready;
  logic [7:0]  read_data;
  logic        irq_line, nmi_pulse, hdma_init_request, hdma_run_request;
  logic        vblank_begin, frame_begin, latch_counters;
  logic [10:0] h_position;
  logic [8:0]  v_position;

  hvt_timer_board board = new();
  bit no_idle = 0;
  int stall_left = 0;
  int cycles = 0;

  hv_timer_irq_and_muldiv_registers_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .reg_offset(reg_offset), .write_data(write_data), .open_bus(open_bus),
    .interlace(interlace), .even_frame(even_frame), .overscan(overscan),
    .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
    .irq_line(irq_line), .nmi_pulse(nmi_pulse),
    .hdma_init_request(hdma_init_request), .hdma_run_request(hdma_run_request),
    .vblank_begin(vblank_begin), .frame_begin(frame_begin),
    .latch_counters(latch_counters), .h_position(h_position),
    .v_position(v_position)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check each transfer, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result('{read_data, irq_line, nmi_pulse, hdma_init_request,
                           hdma_run_request, vblank_begin, frame_begin,
                           latch_counters, h_position, v_position});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(bus_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    operation <= it.op;
    reg_offset <= it.off;
    write_data <= it.wd;
    open_bus <= it.ob;
    interlace <= it.il;
    even_frame <= it.ev;
    overscan <= it.os;
    do @(posedge clk); while (!in_ready);
    board.note_transfer(it);
  endtask

  task automatic send_op(logic [1:0] op, logic [4:0] off, logic [7:0] wd, logic [7:0] ob);
    bus_item_t it;
    it = '{op, off, wd, ob, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1))};
    send(it, gap_len());
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_pal(logic v);
    drain();
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.pal = v;
  endtask

  function automatic bus_item_t rand_item();
    bus_item_t it;
    int r;
    it.op = OP_TICK;
    it.off = 5'($urandom_range(0, 31));
    it.wd = 8'($urandom_range(0, 255));
    it.ob = 8'($urandom_range(0, 255));
    it.il = 1'($urandom_range(0, 1));
    it.ev = 1'($urandom_range(0, 1));
    it.os = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 68) begin
      it.op = OP_TICK;
    end else if (r < 82) begin
      it.op = OP_READ;
      if ($urandom_range(0, 3) != 0) it.off = 5'($urandom_range(REG_RDNMI, REG_RDMPYH));
    end else if (r < 97) begin
      it.op = OP_WRITE;
      if ($urandom_range(0, 4) != 0)
        it.off = 5'($urandom_range(REG_NMITIMEN, REG_VTIMEH));
      // Keep the compare registers within the first lines most of the time.
      if ($urandom_range(0, 3) != 0) begin
        if (it.off == REG_HTIMEH || it.off == REG_VTIMEH) it.wd[0] = 0;
        if (it.off == REG_VTIMEL) it.wd = 8'($urandom_range(0, 1));
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  initial begin
    bus_item_t it;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    operation = OP_TICK;
    reg_offset = 0;
    write_data = 0;
    open_bus = 0;
    interlace = 0;
    even_frame = 0;
    overscan = 0;
    out_ready = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every read register, both multiplier extremes, divide by zero,
    // latch fall, undefined operation, and an early H timer IRQ.
    for (int a = REG_RDNMI; a <= REG_RDMPYH; a++) send_op(OP_READ, 5'(a), 8'h00, 8'hff);
    send_op(OP_READ, REG_NMITIMEN, 8'h00, 8'h00);
    send_op(OP_READ, 5'h1f, 8'h00, 8'hff);
    send_op(OP_WRITE, REG_WRMPYB, 8'hff, 8'h00);
    send_op(OP_WRITE, REG_WRMPYA, 8'h00, 8'h00);
    send_op(OP_WRITE, REG_WRMPYB, 8'hff, 8'h00);
    send_op(OP_WRITE, REG_WRDIVB, 8'h00, 8'h00);
    send_op(OP_WRITE, REG_WRDIVL, 8'h34, 8'h00);
    send_op(OP_WRITE, REG_WRDIVB, 8'hff, 8'h00);
    send_op(OP_READ, REG_RDDIVL, 8'h00, 8'h00);
    send_op(OP_READ, REG_RDMPYL, 8'h00, 8'h00);
    send_op(OP_WRITE, REG_WRIO, 8'h00, 8'h00);
    send_op(OP_WRITE, REG_WRIO, 8'h80, 8'h00);
    send_op(OP_UNUSED, 5'h1f, 8'hff, 8'hff);
    send_op(OP_WRITE, REG_HTIMEL, 8'h05, 8'h00);
    send_op(OP_WRITE, REG_HTIMEH, 8'h00, 8'h00);
    send_op(OP_WRITE, REG_NMITIMEN, 8'h90, 8'h00);
    for (int k = 0; k < 16; k++) send_op(OP_TICK, 5'd0, 8'h00, 8'h00);
    send_op(OP_READ, REG_TIMEUP, 8'h00, 8'h00);

    // Random phases, switching the timing standard between them.
    for (int ph = 0; ph < 6; ph++) begin
      set_pal(ph[0]);
      no_idle = (ph == 3);
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
        it = rand_item();
        send(it, gap_len());
        if (k == 90 && ph == 1) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
